### rtl/gfcas_pkg.sv
// Package: shared types and constants for the grid fill coverage statistics block.
package gfcas_pkg;

   localparam int FRAC = 16;
   localparam int CNT_W = 21;
   localparam int FILL_W = 29;
   localparam int COS_W = 37;

   // Front-to-back item: cell totals contribution, already classified.
   typedef struct packed {
      logic                shape;
      logic                empty;
      logic [7:0]          fill;
      logic                aligned;
      logic [FRAC:0]       cosine;
      logic                last;
      logic [15:0]         paths;
   } cell_type;

   typedef enum logic [1:0] {
      PH_PRODUCTS = 2'd0,
      PH_SUMS     = 2'd1,
      PH_NORMS    = 2'd2,
      PH_SEARCH   = 2'd3
   } front_phase_type;

   typedef enum logic [1:0] {
      ST_ACC  = 2'd0,
      ST_DIV  = 2'd1,
      ST_OUT  = 2'd2
   } back_state_type;

endpackage

### rtl/gfcas_front.sv
// Front part: per-cell cosine search (one bit a cycle) and cell classification.
module gfcas_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    in_shape,
   input  logic [7:0]              fill_count,
   input  logic signed [15:0]      filled_x,
   input  logic signed [15:0]      filled_y,
   input  logic signed [15:0]      desired_x,
   input  logic signed [15:0]      desired_y,
   input  logic [15:0]             path_count,
   input  logic                    last_cell,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gfcas_pkg::cell_type     out_cell
);
   localparam int F = gfcas_pkg::FRAC;
   localparam int SQ_W = 100;

   // stage 0: products
   logic                 busy_ff, busy_in;
   gfcas_pkg::front_phase_type ph_ff, ph_in;
   logic                 done_ff, done_in;
   gfcas_pkg::cell_type  cell_ff, cell_in;
   logic signed [31:0]   p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic [32:0]          nf_ff, nd_ff, ad_ff;
   logic [65:0]          dot2_ff;
   logic [F:0]           c_ff;
   logic [4:0]           bit_ff;
   // search terms: c^2*p, c*p shifted by bit+1, and p shifted by 2*bit
   logic [SQ_W-1:0]      sq_ff, cp_ff, pw_ff;
   logic signed [32:0]   dsum;
   logic [F:0]           t;
   logic [SQ_W-1:0]      cand;
   logic [SQ_W-1:0]      rhs;
   logic                 take;

   assign full = busy_ff;
   assign out_valid = done_ff;
   assign out_cell = cell_ff;

   assign dsum = {p0_ff[31], p0_ff} + {p1_ff[31], p1_ff};
   assign t = c_ff | ((F+1)'(1) << bit_ff);
   // (c + 2^bit)^2 * p, built from the running terms with adds only
   assign cand = sq_ff + cp_ff + pw_ff;
   assign rhs = SQ_W'({dot2_ff, {(2*F){1'b0}}});
   // once c has reached 1.0 no further bit may be added
   assign take = !c_ff[F] && (cand <= rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ph_ff <= gfcas_pkg::PH_PRODUCTS;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ph_ff <= ph_in;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      ph_in = ph_ff;
      cell_in = cell_ff;
      if (done_ff && out_ready) begin
         done_in = 1'b0;
         busy_in = 1'b0;
      end
      if (!busy_ff && push) begin
         busy_in = 1'b1;
         ph_in = gfcas_pkg::PH_PRODUCTS;
         cell_in.shape = in_shape;
         cell_in.empty = in_shape && (fill_count == 8'd0);
         cell_in.fill = fill_count;
         cell_in.aligned = 1'b0;
         cell_in.cosine = '0;
         cell_in.last = last_cell;
         cell_in.paths = path_count;
      end else if (busy_ff && !done_ff) begin
         case (ph_ff)
            gfcas_pkg::PH_PRODUCTS: ph_in = gfcas_pkg::PH_SUMS;
            gfcas_pkg::PH_SUMS: ph_in = gfcas_pkg::PH_NORMS;
            gfcas_pkg::PH_NORMS: begin
               if (cell_ff.fill != 8'd0 && nf_ff != '0 && nd_ff != '0) begin
                  cell_in.aligned = 1'b1;
                  ph_in = gfcas_pkg::PH_SEARCH;
               end else begin
                  done_in = 1'b1;
               end
            end
            gfcas_pkg::PH_SEARCH: begin
               if (bit_ff == 5'd0) begin
                  cell_in.cosine = take ? t : c_ff;
                  done_in = 1'b1;
               end
            end
            default: ph_in = gfcas_pkg::PH_PRODUCTS;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (!busy_ff && push) begin
         p0_ff <= filled_x * desired_x;
         p1_ff <= filled_y * desired_y;
         p2_ff <= filled_x * filled_x;
         p3_ff <= filled_y * filled_y;
         p4_ff <= desired_x * desired_x;
         p5_ff <= desired_y * desired_y;
      end
      if (busy_ff && ph_ff == gfcas_pkg::PH_SUMS) begin
         ad_ff <= dsum[32] ? 33'(-dsum) : 33'(dsum);
         nf_ff <= 33'(unsigned'(p2_ff)) + 33'(unsigned'(p3_ff));
         nd_ff <= 33'(unsigned'(p4_ff)) + 33'(unsigned'(p5_ff));
      end
      if (busy_ff && ph_ff == gfcas_pkg::PH_NORMS) begin
         dot2_ff <= 66'(ad_ff) * 66'(ad_ff);
         sq_ff <= '0;
         cp_ff <= '0;
         pw_ff <= SQ_W'(66'(nf_ff) * 66'(nd_ff)) << (2*F);
         c_ff <= '0;
         bit_ff <= 5'(F);
      end
      if (busy_ff && ph_ff == gfcas_pkg::PH_SEARCH && !done_ff) begin
         if (take) begin
            c_ff <= t;
            sq_ff <= cand;
            cp_ff <= (cp_ff >> 1) + pw_ff;
         end else begin
            cp_ff <= cp_ff >> 1;
         end
         pw_ff <= pw_ff >> 2;
         if (bit_ff != 5'd0)
            bit_ff <= bit_ff - 5'd1;
      end
   end
endmodule

### rtl/gfcas_fifo.sv
// Short queue between the front and back parts.
module gfcas_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gfcas_pkg::cell_type  in_cell,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gfcas_pkg::cell_type  out_cell
);
   gfcas_pkg::cell_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cell = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_cell;
   end
endmodule

### rtl/gfcas_div.sv
// Restoring divider: 48-bit dividend by 24-bit divisor, one quotient bit per cycle.
module gfcas_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [23:0] divisor,
   output logic        done,
   output logic [47:0] quotient,
   output logic [23:0] remainder
);
   logic [47:0] q_ff;
   logic [24:0] r_ff;
   logic [23:0] d_ff;
   logic [5:0]  n_ff;
   logic        run_ff;
   logic [24:0] sh;
   logic        ge;

   assign sh = {r_ff[23:0], q_ff[47]};
   assign ge = sh >= {1'b0, d_ff};
   assign quotient = q_ff;
   assign remainder = r_ff[23:0];
   assign done = run_ff && n_ff == 6'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (done) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
         n_ff <= 6'd48;
      end else if (run_ff && n_ff != 6'd0) begin
         r_ff <= ge ? sh - {1'b0, d_ff} : sh;
         q_ff <= {q_ff[46:0], ge};
         n_ff <= n_ff - 6'd1;
      end
   end
endmodule

### rtl/gfcas_back.sv
// Back part: totals, final divisions and the result register.
module gfcas_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gfcas_pkg::cell_type  in_cell,
   input  logic [12:0]          grid_width,
   input  logic [12:0]          grid_height,
   output logic                 rsp_empty,
   input  logic                 pop,
   output logic [16:0]          rsp_empty_fraction,
   output logic signed [24:0]   rsp_overlap,
   output logic [16:0]          rsp_disagreement,
   output logic [31:0]          rsp_paths_per_side,
   output logic [1:0]           rsp_status
);
   localparam int F = gfcas_pkg::FRAC;
   localparam int CW = gfcas_pkg::CNT_W;
   localparam int FW = gfcas_pkg::FILL_W;
   localparam int SW = gfcas_pkg::COS_W;

   localparam logic [1:0] JOB_EMPTY   = 2'd0;
   localparam logic [1:0] JOB_OVERLAP = 2'd1;
   localparam logic [1:0] JOB_COSINE  = 2'd2;
   localparam logic [1:0] JOB_PATHS   = 2'd3;

   gfcas_pkg::back_state_type st_ff, st_in;
   logic [CW-1:0] shp_ff, emp_ff, aln_ff;
   logic [FW-1:0] fil_ff;
   logic [SW-1:0] cos_ff;
   logic [15:0]   paths_ff;
   logic [1:0]    job_ff;
   logic          start_ff;
   logic          full_ff;
   logic [16:0]   ef_ff, dis_ff;
   logic signed [24:0] ovl_ff;
   logic [31:0]   pps_ff;
   logic [16:0]   out_ef_ff, out_dis_ff;
   logic signed [24:0] out_ovl_ff;
   logic [31:0]   out_pps_ff;
   logic [1:0]    stat_ff;
   logic          neg_ff;
   logic [47:0]   dvd;
   logic [23:0]   dvs;
   logic          ddone;
   logic [47:0]   quo;
   logic [23:0]   rem;
   logic          acc;
   logic [FW:0]   fsum;
   logic [SW:0]   csum;
   logic [CW-1:0] shp_n, emp_n;
   logic [FW-1:0] fil_n;
   logic [CW-1:0] aln_n;
   logic [SW-1:0] cos_n;
   logic signed [FW+1:0] onum;
   logic [FW+1:0] oabs;
   logic signed [49:0] qs;
   logic [12:0]   side;

   assign in_ready = st_ff == gfcas_pkg::ST_ACC;
   assign acc = in_valid && in_ready;
   assign rsp_empty = !full_ff;
   assign rsp_empty_fraction = out_ef_ff;
   assign rsp_overlap = out_ovl_ff;
   assign rsp_disagreement = out_dis_ff;
   assign rsp_paths_per_side = out_pps_ff;
   assign rsp_status = stat_ff;

   // accumulated totals including the incoming cell
   always_comb begin
      shp_n = shp_ff;
      emp_n = emp_ff;
      aln_n = aln_ff;
      cos_n = cos_ff;
      if (in_cell.shape && shp_ff != '1) shp_n = shp_ff + CW'(1);
      if (in_cell.empty && emp_ff != '1) emp_n = emp_ff + CW'(1);
      fsum = {1'b0, fil_ff} + (FW+1)'(in_cell.fill);
      fil_n = fsum[FW] ? '1 : fsum[FW-1:0];
      csum = {1'b0, cos_ff} + (SW+1)'(in_cell.cosine);
      if (in_cell.aligned && aln_ff != '1) begin
         aln_n = aln_ff + CW'(1);
         cos_n = csum[SW] ? '1 : csum[SW-1:0];
      end
   end

   assign onum = signed'({2'b00, fil_ff}) + signed'((FW+2)'(emp_ff))
                 - signed'((FW+2)'(shp_ff));
   assign oabs = onum[FW+1] ? (FW+2)'(-onum) : (FW+2)'(onum);
   assign side = (grid_width > grid_height) ? grid_width : grid_height;

   always_comb begin
      case (job_ff)
         JOB_EMPTY: begin dvd = 48'(emp_ff) << F; dvs = 24'(shp_ff); end
         JOB_OVERLAP: begin dvd = 48'(oabs) << F; dvs = 24'(shp_ff); end
         JOB_COSINE: begin dvd = 48'(cos_ff); dvs = 24'(aln_ff); end
         default: begin
            dvd = 48'(paths_ff) << F;
            dvs = (side == 13'd0) ? 24'd1 : 24'(side);
         end
      endcase
   end

   gfcas_div u_div (
      .clock(clock), .reset(reset), .start(start_ff), .dividend(dvd), .divisor(dvs),
      .done(ddone), .quotient(quo), .remainder(rem)
   );

   // floor for negative numerators: -(q) or -(q+1)
   assign qs = neg_ff ? -(signed'({2'b00, quo}) + ((rem != '0) ? 50'sd1 : 50'sd0))
                      : signed'({2'b00, quo});

   always_ff @(posedge clock) begin
      if (reset) st_ff <= gfcas_pkg::ST_ACC;
      else st_ff <= st_in;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         gfcas_pkg::ST_ACC: if (acc && in_cell.last) st_in = gfcas_pkg::ST_DIV;
         gfcas_pkg::ST_DIV: if (ddone && job_ff == JOB_PATHS) st_in = gfcas_pkg::ST_OUT;
         gfcas_pkg::ST_OUT: if (!full_ff) st_in = gfcas_pkg::ST_ACC;
         default: st_in = gfcas_pkg::ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shp_ff <= '0; emp_ff <= '0; fil_ff <= '0; aln_ff <= '0; cos_ff <= '0;
         full_ff <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (full_ff && pop) full_ff <= 1'b0;
         case (st_ff)
            gfcas_pkg::ST_ACC: begin
               if (acc) begin
                  shp_ff <= shp_n; emp_ff <= emp_n; fil_ff <= fil_n;
                  aln_ff <= aln_n; cos_ff <= cos_n;
                  if (in_cell.last) begin
                     paths_ff <= in_cell.paths;
                     job_ff <= JOB_EMPTY;
                     start_ff <= 1'b1;
                  end
               end
            end
            gfcas_pkg::ST_DIV: begin
               neg_ff <= onum[FW+1];
               if (ddone) begin
                  case (job_ff)
                     JOB_EMPTY: ef_ff <= (shp_ff == '0) ? 17'd0 : quo[16:0];
                     JOB_OVERLAP: begin
                        if (shp_ff == '0) ovl_ff <= '0;
                        else if (qs > 50'sd16777215) ovl_ff <= 25'sd16777215;
                        else if (qs < -50'sd8388608) ovl_ff <= -25'sd8388608;
                        else ovl_ff <= qs[24:0];
                     end
                     JOB_COSINE: dis_ff <= (aln_ff == '0) ? 17'd0 :
                                     (quo > 48'(1 << F)) ? 17'd0 : 17'((1 << F) - quo);
                     default: pps_ff <= (quo[47:32] != '0) ? '1 : quo[31:0];
                  endcase
                  if (job_ff != JOB_PATHS) begin
                     job_ff <= job_ff + 2'd1;
                     start_ff <= 1'b1;
                  end
               end
            end
            gfcas_pkg::ST_OUT: begin
               if (!full_ff) begin
                  full_ff <= 1'b1;
                  out_ef_ff <= ef_ff;
                  out_ovl_ff <= ovl_ff;
                  out_dis_ff <= dis_ff;
                  out_pps_ff <= pps_ff;
                  stat_ff <= {aln_ff == '0, shp_ff == '0};
                  shp_ff <= '0; emp_ff <= '0; fil_ff <= '0; aln_ff <= '0; cos_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

### rtl/grid_fill_coverage_alignment_stats.sv
// Top level: grid fill coverage and alignment statistics.
// Cells enter through a queue-style port (push/full) in raster order, one at a time. The
// front part runs a bit-serial cosine search, one bit a cycle, on each aligned cell and
// takes the next cell once the two-entry queue behind it has taken the finished one; the
// back part adds a queued cell into the running totals while the front already works on the
// next. On the cell marked last, the back part runs four divisions one after the other on
// one shared restoring divider and loads the result into the output register once they are
// done, or later while the previous result still waits to be popped; no cells are added to
// the totals until then.
// grid_width and grid_height are written through the csr_ port; the user must write them
// only while idle, which the block itself does not enforce.
module grid_fill_coverage_alignment_stats (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_in_shape,
   input  logic [7:0]         req_fill_count,
   input  logic signed [15:0] req_filled_x,
   input  logic signed [15:0] req_filled_y,
   input  logic signed [15:0] req_desired_x,
   input  logic signed [15:0] req_desired_y,
   input  logic [15:0]        req_path_count,
   input  logic               req_last_cell,
   output logic               empty,
   input  logic               pop,
   output logic [16:0]        rsp_empty_fraction,
   output logic signed [24:0] rsp_overlap,
   output logic [16:0]        rsp_disagreement,
   output logic [31:0]        rsp_paths_per_side,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [12:0]        csr_data
);
   localparam logic [0:0] REG_WIDTH = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   logic [12:0] width_ff, height_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   gfcas_pkg::cell_type f_cell, q_cell;

   assign csr_ready = 1'b1;

   // hold the grid size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd1024;
         height_ff <= 13'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WIDTH: width_ff <= csr_data;
            REG_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gfcas_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .in_shape(req_in_shape), .fill_count(req_fill_count),
      .filled_x(req_filled_x), .filled_y(req_filled_y),
      .desired_x(req_desired_x), .desired_y(req_desired_y),
      .path_count(req_path_count), .last_cell(req_last_cell),
      .out_valid(f_valid), .out_ready(f_ready), .out_cell(f_cell)
   );

   gfcas_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_cell(f_cell),
      .out_valid(q_valid), .out_ready(q_ready), .out_cell(q_cell)
   );

   gfcas_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_cell(q_cell),
      .grid_width(width_ff), .grid_height(height_ff),
      .rsp_empty(empty), .pop(pop),
      .rsp_empty_fraction(rsp_empty_fraction), .rsp_overlap(rsp_overlap),
      .rsp_disagreement(rsp_disagreement), .rsp_paths_per_side(rsp_paths_per_side),
      .rsp_status(rsp_status)
   );
endmodule

### verif/grid_fill_coverage_alignment_stats_tb.sv
// Testbench for the grid fill coverage and alignment statistics block.
module grid_fill_coverage_alignment_stats_tb;

   // Register indexes of the csr_ port.
   typedef enum logic [0:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } reg_index_type;

   // Status bits of a grid summary.
   localparam logic [1:0] STATUS_NO_SHAPE   = 2'b01;
   localparam logic [1:0] STATUS_NO_ALIGNED = 2'b10;

   localparam int        ONE_Q16     = 65536;
   localparam longint    CNT_FULL    = (64'd1 << 21) - 1;
   localparam longint    FILL_FULL   = (64'd1 << 29) - 1;
   localparam longint    COS_FULL    = (64'd1 << 37) - 1;
   localparam longint    OVL_LOW     = -64'sd8388608;
   localparam longint    OVL_HIGH    = 64'sd16777215;
   localparam int        CYCLE_LIMIT = 1000000;
   localparam int        SETTLE      = 300;
   localparam int        ITEM_TARGET = 950;

   typedef struct {
      bit               shape;
      bit [7:0]         fill;
      bit signed [15:0] fx;
      bit signed [15:0] fy;
      bit signed [15:0] dx;
      bit signed [15:0] dy;
      bit [15:0]        paths;
      bit               last;
   } cell_type;

   typedef struct {
      bit [16:0]        empty_fraction;
      bit signed [24:0] overlap;
      bit [16:0]        disagreement;
      bit [31:0]        paths_per_side;
      bit [1:0]         status;
   } summary_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic               req_in_shape = 1'b0;
   logic [7:0]         req_fill_count = '0;
   logic signed [15:0] req_filled_x = '0;
   logic signed [15:0] req_filled_y = '0;
   logic signed [15:0] req_desired_x = '0;
   logic signed [15:0] req_desired_y = '0;
   logic [15:0]        req_path_count = '0;
   logic               req_last_cell = 1'b0;
   logic               empty;
   logic               pop = 1'b0;
   logic [16:0]        rsp_empty_fraction;
   logic signed [24:0] rsp_overlap;
   logic [16:0]        rsp_disagreement;
   logic [31:0]        rsp_paths_per_side;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [0:0]         csr_index = '0;
   logic [12:0]        csr_data = '0;

   grid_fill_coverage_alignment_stats u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor copy of the registers and running totals.
   longint unsigned grid_width_q  = 1024;
   longint unsigned grid_height_q = 1024;
   longint unsigned shape_cells_q, empty_cells_q, fill_total_q;
   longint unsigned aligned_cells_q, cosine_total_q;

   summary_type pending_summaries[$];
   int          mismatches = 0;
   int          cells_sent = 0;
   int          cycle_count = 0;
   int          burst_left = 0;

   // Largest c in [0, 1.0] with c^2 * p <= dot^2 * 2^32, found bit by bit.
   function automatic longint unsigned cosine_q16(longint unsigned dot2, longint unsigned p);
      logic [127:0]    rhs;
      logic [127:0]    lhs;
      longint unsigned c;
      longint unsigned t;
      rhs = {64'd0, dot2} << 32;
      c = 0;
      for (int b = 16; b >= 0; b--) begin
         t = c | (64'd1 << b);
         if (t <= ONE_Q16) begin
            lhs = 128'(t) * 128'(t) * 128'(p);
            if (lhs <= rhs) c = t;
         end
      end
      return c;
   endfunction

   // Fold one accepted cell into the totals; on the last cell queue the summary.
   task automatic fold_cell(input cell_type c);
      longint      fx, fy, dx, dy, dot, num, q;
      longint unsigned nf, nd, ad, side, mean;
      summary_type s;
      fx = c.fx; fy = c.fy; dx = c.dx; dy = c.dy;
      if (c.shape) begin
         if (shape_cells_q < CNT_FULL) shape_cells_q++;
         if (c.fill == 0 && empty_cells_q < CNT_FULL) empty_cells_q++;
      end
      fill_total_q = (fill_total_q + c.fill > FILL_FULL) ? FILL_FULL : fill_total_q + c.fill;
      if (c.fill > 0) begin
         nf = fx * fx + fy * fy;
         nd = dx * dx + dy * dy;
         if (nf != 0 && nd != 0 && aligned_cells_q < CNT_FULL) begin
            dot = fx * dx + fy * dy;
            ad = (dot < 0) ? -dot : dot;
            aligned_cells_q++;
            cosine_total_q += cosine_q16(ad * ad, nf * nd);
            if (cosine_total_q > COS_FULL) cosine_total_q = COS_FULL;
         end
      end
      if (!c.last) return;
      s = '{default: 0};
      if (shape_cells_q == 0) begin
         s.status |= STATUS_NO_SHAPE;
      end else begin
         s.empty_fraction = 17'((empty_cells_q << 16) / shape_cells_q);
         num = (longint'(fill_total_q) + longint'(empty_cells_q)
                - longint'(shape_cells_q)) * ONE_Q16;
         q = num / longint'(shape_cells_q);
         if (num % longint'(shape_cells_q) != 0 && num < 0) q--;
         if (q < OVL_LOW) q = OVL_LOW;
         if (q > OVL_HIGH) q = OVL_HIGH;
         s.overlap = q[24:0];
      end
      if (aligned_cells_q == 0) begin
         s.status |= STATUS_NO_ALIGNED;
      end else begin
         mean = cosine_total_q / aligned_cells_q;
         s.disagreement = (mean > ONE_Q16) ? 17'd0 : 17'(ONE_Q16 - mean);
      end
      side = (grid_width_q > grid_height_q) ? grid_width_q : grid_height_q;
      if (side == 0) side = 1;
      mean = (longint'(c.paths) << 16) / side;
      s.paths_per_side = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
      pending_summaries.push_back(s);
      shape_cells_q = 0; empty_cells_q = 0; fill_total_q = 0;
      aligned_cells_q = 0; cosine_total_q = 0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      mismatches++;
   endtask

   // Drive one cell and hold it until accepted; push stays high for the next one.
   task automatic send_cell(input cell_type c);
      @(negedge clock);
      push           <= 1'b1;
      req_in_shape   <= c.shape;
      req_fill_count <= c.fill;
      req_filled_x   <= c.fx;
      req_filled_y   <= c.fy;
      req_desired_x  <= c.dx;
      req_desired_y  <= c.dy;
      req_path_count <= c.paths;
      req_last_cell  <= c.last;
      do @(posedge clock); while (full);
      fold_cell(c);
      cells_sent++;
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      push <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Sender pacing: bursts of random length, then a random gap.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 12);
         hold_off($urandom_range(1, 15));
      end
   endtask

   // Write a register once the block is idle: drop push, let it settle, drain summaries.
   task automatic write_reg(input reg_index_type idx, input logic [12:0] value);
      hold_off(SETTLE);
      wait (pending_summaries.size() == 0);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_GRID_WIDTH) grid_width_q = value;
      else grid_height_q = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_grid(input logic [12:0] w, input logic [12:0] h);
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
   endtask

   function automatic cell_type make_cell(input bit sh, input int fill, input int fx,
                                          input int fy, input int dx, input int dy,
                                          input int paths, input bit last);
      cell_type c;
      c.shape = sh; c.fill = 8'(fill); c.fx = 16'(fx); c.fy = 16'(fy);
      c.dx = 16'(dx); c.dy = 16'(dy);
      c.paths = 16'(paths); c.last = last;
      return c;
   endfunction

   function automatic bit [15:0] rand_component();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cell_type rand_cell(input bit last);
      cell_type c;
      c.shape = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 5))
         0: c.fill = 8'd0;
         1: c.fill = 8'd255;
         default: c.fill = 8'($urandom_range(1, 6));
      endcase
      c.fx = rand_component(); c.fy = rand_component();
      case ($urandom_range(0, 4))
         0: begin c.dx = c.fx; c.dy = c.fy; end
         1: begin c.dx = -c.fy; c.dy = c.fx; end
         default: begin c.dx = rand_component(); c.dy = rand_component(); end
      endcase
      c.paths = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
      c.last = last;
      return c;
   endfunction

   // Extremes, zero vectors, empty grids, overlap saturation.
   task automatic test_directed_cells();
      // grid with no shape and no aligned cells
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 1));
      // extreme vectors, parallel, antiparallel and perpendicular
      send_cell(make_cell(1, 255, -32768, -32768, -32768, -32768, 0, 0));
      send_cell(make_cell(1, 1, 32767, 32767, -32768, -32768, 0, 0));
      send_cell(make_cell(1, 1, 32767, 0, 0, 32767, 0, 0));
      send_cell(make_cell(1, 0, 100, 200, 300, 400, 65535, 1));
      // zero vectors and zero fill keep cells out of the cosine sum
      send_cell(make_cell(1, 3, 0, 0, 5, 5, 0, 0));
      send_cell(make_cell(1, 3, 5, 5, 0, 0, 0, 0));
      send_cell(make_cell(0, 0, 5, 5, 5, 5, 1, 1));
      // heavy fill on one shape cell saturates the overlap high
      send_cell(make_cell(1, 255, 1, 2, 3, 4, 0, 0));
      send_cell(make_cell(0, 255, 1, 2, 3, 4, 0, 0));
      send_cell(make_cell(0, 255, -1, 2, 3, -4, 32768, 1));
      // all shape cells empty
      send_cell(make_cell(1, 0, -1, -1, 1, 1, 0, 0));
      send_cell(make_cell(1, 0, 7, -9, 3, 2, 12345, 1));
      // oblique vectors
      send_cell(make_cell(1, 2, 12000, -5000, 3000, 31000, 0, 0));
      send_cell(make_cell(0, 9, 1, 1, 1, -2, 0, 0));
      send_cell(make_cell(1, 1, -3, 4, 4, 3, 1000, 1));
   endtask

   // Path normalization under extreme grid sizes, both sizes zero included.
   task automatic test_grid_sizes();
      logic [12:0] widths[5]  = '{13'd1, 13'd0, 13'd8191, 13'd4096, 13'd1};
      logic [12:0] heights[5] = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd4096};
      for (int i = 0; i < 5; i++) begin
         set_grid(widths[i], heights[i]);
         send_cell(make_cell(1, 1, 1, 0, 1, 0, 65535, 1));
         send_cell(make_cell(0, 0, 0, 0, 0, 0, 16'h5555, 1));
      end
   endtask

   // Random grids, mostly short, some long, with occasional size changes.
   task automatic test_random_grids();
      int len;
      int grids = 0;
      while (cells_sent < ITEM_TARGET) begin
         if (grids % 40 == 39)
            set_grid(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            send_cell(rand_cell(i == len - 1));
            pace_sender();
         end
         grids++;
      end
      set_grid(13'd1024, 13'd1024);
      send_cell(rand_cell(1'b1));
   endtask

   // Receiver stalls: phases of steady pop, random pop and a fixed pattern.
   always @(negedge clock) begin
      case ((cycle_count / 1500) % 3)
         0: pop <= 1'b1;
         1: pop <= $urandom_range(0, 1);
         default: pop <= (cycle_count % 23) > 9;
      endcase
   end

   // Compare each popped summary with the oldest expectation.
   always @(posedge clock) begin
      summary_type want;
      if (!reset && pop && !empty) begin
         if (pending_summaries.size() == 0) begin
            report_mismatch("unexpected summary", 1, 0);
         end else begin
            want = pending_summaries.pop_front();
            if (rsp_empty_fraction !== want.empty_fraction)
               report_mismatch("empty_fraction", rsp_empty_fraction, want.empty_fraction);
            if (rsp_overlap !== want.overlap)
               report_mismatch("overlap", rsp_overlap, want.overlap);
            if (rsp_disagreement !== want.disagreement)
               report_mismatch("disagreement", rsp_disagreement, want.disagreement);
            if (rsp_paths_per_side !== want.paths_per_side)
               report_mismatch("paths_per_side", rsp_paths_per_side, want.paths_per_side);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cells();
      test_grid_sizes();
      test_random_grids();
      hold_off(1);
      wait (pending_summaries.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_summaries.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/gfcas_pkg.sv
rtl/gfcas_front.sv
rtl/gfcas_fifo.sv
rtl/gfcas_div.sv
rtl/gfcas_back.sv
rtl/grid_fill_coverage_alignment_stats.sv
verif/grid_fill_coverage_alignment_stats_tb.sv
